// File: rtl/gmi_pkg.sv
// Shared types, constants and table builder for the midpoint Gaussian integrator.
// Depends on nothing; used by midpoint_gaussian_integrator.
package gmi_pkg;

    localparam int MAX_STEPS_DEF       = 65536;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    localparam int BOUND_W = 16;
    localparam int COUNT_W = 17;
    localparam int RES_W   = 32;
    localparam int SUM_W   = 48;
    localparam int POS_W   = 32;
    localparam int QUO_W   = 31;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int X0_W    = 29;
    localparam int GAUSS_W = 32;
    localparam int ROM_W   = X0_W + GAUSS_W;
    localparam int DIVC_W  = 5;

    localparam logic [32:0]       ONE_Q32  = 33'h1_0000_0000;
    localparam logic [MUL_W-1:0]  RECIP6   = 34'h2_AAAA_AAAB;
    localparam longint unsigned   LN2_Q32  = 64'd2977044472;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_INIT,
        ST_MUL_K,
        ST_ROM,
        ST_MUL_D,
        ST_MUL_T,
        ST_MUL_T2,
        ST_MUL_T3,
        ST_MUL_P,
        ST_ACC,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_FINISH
    } gmi_state_t;

    // exp(-x0*x0) in Q31 at a grid point given in Q2.27
    function automatic logic [GAUSS_W-1:0] gauss_entry(input logic [X0_W-1:0] x0);
        longint unsigned y;
        longint unsigned m;
        longint unsigned r;
        longint unsigned term;
        longint unsigned acc_u;
        longint          acc;
        int unsigned     j;
        y = (64'(x0) * 64'(x0)) >> 22;
        m = y / LN2_Q32;
        if (m > 64'd40)
        begin
            return '0;
        end
        r    = y - m * LN2_Q32;
        term = 64'h1_0000_0000;
        acc  = 64'sh1_0000_0000;
        for (j = 1; j <= 16; j++)
        begin
            term = ((term * r) >> 32) / 64'(j);
            if (j[0])
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        acc_u = longint'(acc);
        return GAUSS_W'((acc_u >> m) >> 1);
    endfunction

endpackage

// File: rtl/midpoint_gaussian_integrator.sv
// Midpoint-rule integrator of exp(-x*x) over one request of bounds and step count.
// Uses gmi_pkg for the sequencer states, widths and the table builder.
//
// Usage: a request carries lower_bound, upper_bound (signed Q4.12) and step_count.
// It is taken when req_valid and req_ready are both high; req_ready is high only
// while the sequencer is idle. The single result, integral (signed Q3.29,
// saturated), is offered on rsp_valid/rsp_ready from an output register, so a new
// request is taken while a finished result still waits.
// The step width comes from a restoring divider, one quotient bit a cycle. Each
// midpoint then uses one shared 34x34 multiplier six times plus a table read
// and an accumulate, or the multiplier only once and no table read where the
// midpoint lies beyond the table. Scaling runs through ST_SCALE_LO and ST_SCALE_HI.
// A zero step_count skips the divider and the midpoints; after ST_FINISH the
// sequencer returns to idle before the next request is taken.
// Reset clears the sequencer and the result valid; no clearing pass is needed.
// When the receiver stalls, the next result holds in the final state until the
// output register frees, and no further request is taken meanwhile.
module midpoint_gaussian_integrator #(
    parameter int MAX_STEPS       = gmi_pkg::MAX_STEPS_DEF,
    parameter int EXP_TABLE_DEPTH = gmi_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic signed [gmi_pkg::BOUND_W-1:0]   lower_bound,
    input  logic signed [gmi_pkg::BOUND_W-1:0]   upper_bound,
    input  logic        [gmi_pkg::COUNT_W-1:0]   step_count,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output logic signed [gmi_pkg::RES_W-1:0]     integral
);

    localparam int NW  = $clog2(MAX_STEPS + 1);
    localparam int CW  = (NW > gmi_pkg::COUNT_W) ? NW : gmi_pkg::COUNT_W;
    localparam int AW  = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam int KW  = gmi_pkg::PROD_W - 29;
    localparam int PW  = gmi_pkg::PROD_W;
    localparam int MW  = gmi_pkg::MUL_W;

    gmi_pkg::gmi_state_t state_reg, state_next;

    logic                              rsp_valid_reg, rsp_valid_next;
    logic [gmi_pkg::RES_W-1:0]         integral_reg, integral_next;
    logic [gmi_pkg::DIVC_W-1:0]        div_cnt_reg, div_cnt_next;
    logic [NW-1:0]                     rem_reg, rem_next;
    logic [gmi_pkg::QUO_W-1:0]         quo_reg, quo_next;
    logic                              neg_reg, neg_next;
    logic [gmi_pkg::BOUND_W-1:0]       a_reg, a_next;
    logic [NW-1:0]                     n_reg, n_next;
    logic [NW-1:0]                     idx_reg, idx_next;
    logic [gmi_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [gmi_pkg::POS_W-1:0]         ax_reg, ax_next;
    logic [PW-1:0]                     prod_reg, prod_next;
    logic [gmi_pkg::ROM_W-1:0]         rom_word_reg;
    logic                              zero_reg, zero_next;
    logic [32:0]                       t_reg, t_next;
    logic [32:0]                       t2_reg, t2_next;
    logic [gmi_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [31:0]                       lo_reg, lo_next;

    logic [MW-1:0]                     mul_a;
    logic [MW-1:0]                     mul_b;
    logic                              rom_rd;
    logic [AW-1:0]                     rom_addr;

    logic [gmi_pkg::ROM_W-1:0]         rom_tab [EXP_TABLE_DEPTH];

    logic                              out_free;
    logic                              n_zero;
    logic                              last_div;
    logic                              last_step;
    logic                              k_oor;
    logic [KW-1:0]                     k_full;
    logic [CW-1:0]                     n_ext;
    logic [CW-1:0]                     n_sat;
    logic [16:0]                       diff;
    logic [16:0]                       diff_abs;
    logic [NW:0]                       trial;
    logic                              trial_ge;
    logic [gmi_pkg::POS_W-1:0]         h_val;
    logic [gmi_pkg::POS_W-1:0]         half_val;
    logic [gmi_pkg::POS_W-1:0]         a_pos;
    logic [gmi_pkg::X0_W-1:0]          x0;
    logic [31:0]                       d_val;
    logic [35:0]                       p_wide;
    logic [32:0]                       p_val;
    logic [gmi_pkg::SUM_W:0]           sum_wide;
    logic [56:0]                       mag_sum;
    logic [51:0]                       mag;
    logic [NW-1:0]                     idx_inc;

    for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++)
    begin : g_rom
        localparam logic [gmi_pkg::X0_W-1:0] X0 =
            gmi_pkg::X0_W'((64'(gi) << 29) / EXP_TABLE_DEPTH);
        assign rom_tab[gi] = {X0, gmi_pkg::gauss_entry(X0)};
    end

    assign req_ready = (state_reg == gmi_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign integral  = integral_reg;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign n_ext     = CW'(step_count);
    assign n_sat     = (n_ext > CW'(MAX_STEPS)) ? CW'(MAX_STEPS) : n_ext;
    assign n_zero    = (step_count == '0);
    assign last_div  = (div_cnt_reg == gmi_pkg::DIVC_W'(gmi_pkg::QUO_W - 1));
    assign idx_inc   = idx_reg + NW'(1);
    assign last_step = (idx_inc == n_reg);
    assign k_full    = prod_reg[PW-1:29];
    assign k_oor     = (k_full >= KW'(EXP_TABLE_DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gmi_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = n_zero ? gmi_pkg::ST_SCALE_LO : gmi_pkg::ST_DIV;
                end
            end
            gmi_pkg::ST_DIV:
            begin
                if (last_div)
                begin
                    state_next = gmi_pkg::ST_INIT;
                end
            end
            gmi_pkg::ST_INIT:     state_next = gmi_pkg::ST_MUL_K;
            gmi_pkg::ST_MUL_K:    state_next = gmi_pkg::ST_ROM;
            gmi_pkg::ST_ROM:      state_next = k_oor ? gmi_pkg::ST_ACC : gmi_pkg::ST_MUL_D;
            gmi_pkg::ST_MUL_D:    state_next = gmi_pkg::ST_MUL_T;
            gmi_pkg::ST_MUL_T:    state_next = gmi_pkg::ST_MUL_T2;
            gmi_pkg::ST_MUL_T2:   state_next = gmi_pkg::ST_MUL_T3;
            gmi_pkg::ST_MUL_T3:   state_next = gmi_pkg::ST_MUL_P;
            gmi_pkg::ST_MUL_P:    state_next = gmi_pkg::ST_ACC;
            gmi_pkg::ST_ACC:
            begin
                state_next = last_step ? gmi_pkg::ST_SCALE_LO : gmi_pkg::ST_MUL_K;
            end
            gmi_pkg::ST_SCALE_LO: state_next = gmi_pkg::ST_SCALE_HI;
            gmi_pkg::ST_SCALE_HI: state_next = gmi_pkg::ST_FINISH;
            gmi_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = gmi_pkg::ST_IDLE;
                end
            end
            default:              state_next = gmi_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        integral_next  = integral_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        a_next         = a_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        ax_next        = ax_reg;
        zero_next      = zero_reg;
        t_next         = t_reg;
        t2_next        = t2_reg;
        sum_next       = sum_reg;
        lo_next        = lo_reg;
        mul_a          = '0;
        mul_b          = '0;
        rom_rd         = 1'b0;
        rom_addr       = k_full[AW-1:0];

        diff     = 17'({upper_bound[15], upper_bound}) - 17'({lower_bound[15], lower_bound});
        diff_abs = diff[16] ? (17'd0 - diff) : diff;
        trial    = {rem_reg, quo_reg[gmi_pkg::QUO_W-1]};
        trial_ge = (trial >= {1'b0, n_reg});
        h_val    = neg_reg ? (32'd0 - 32'(quo_reg)) : 32'(quo_reg);
        half_val = neg_reg ? (32'd0 - 32'(quo_reg[gmi_pkg::QUO_W-1:1]))
                           : 32'(quo_reg[gmi_pkg::QUO_W-1:1]);
        a_pos    = {a_reg[15], a_reg, 15'd0};
        x0       = rom_word_reg[gmi_pkg::ROM_W-1:gmi_pkg::GAUSS_W];
        d_val    = ax_reg - 32'(x0);
        p_wide   = 36'(gmi_pkg::ONE_Q32) - 36'(t_reg) + 36'(t2_reg[32:1])
                   - 36'(prod_reg[PW-1:36]);
        p_val    = p_wide[35] ? 33'd0 : p_wide[32:0];
        sum_wide = (gmi_pkg::SUM_W + 1)'(sum_reg)
                   + (gmi_pkg::SUM_W + 1)'(zero_reg ? 32'd0 : prod_reg[63:32]);
        mag_sum  = 57'(prod_reg[55:0]) + 57'(lo_reg);
        mag      = mag_sum[56:5];

        unique case (state_reg)
            gmi_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    a_next       = lower_bound;
                    n_next       = n_sat[NW-1:0];
                    neg_next     = diff[16];
                    quo_next     = n_zero ? '0 : {diff_abs[15:0], 15'd0};
                    rem_next     = '0;
                    div_cnt_next = '0;
                    sum_next     = '0;
                end
            end
            gmi_pkg::ST_DIV:
            begin
                rem_next     = trial_ge ? NW'(trial - {1'b0, n_reg}) : NW'(trial);
                quo_next     = {quo_reg[gmi_pkg::QUO_W-2:0], trial_ge};
                div_cnt_next = div_cnt_reg + gmi_pkg::DIVC_W'(1);
            end
            gmi_pkg::ST_INIT:
            begin
                pos_next = a_pos + half_val;
                sum_next = '0;
                idx_next = '0;
            end
            gmi_pkg::ST_MUL_K:
            begin
                ax_next = pos_reg[gmi_pkg::POS_W-1] ? (32'd0 - pos_reg) : pos_reg;
                mul_a   = MW'(ax_next);
                mul_b   = MW'(EXP_TABLE_DEPTH);
            end
            gmi_pkg::ST_ROM:
            begin
                zero_next = k_oor;
                rom_rd    = !k_oor;
            end
            gmi_pkg::ST_MUL_D:
            begin
                mul_a = MW'(d_val);
                mul_b = MW'({x0, 1'b0}) + MW'(d_val);
            end
            gmi_pkg::ST_MUL_T:
            begin
                t_next = (prod_reg[PW-1:22] > (PW - 22)'(gmi_pkg::ONE_Q32))
                         ? gmi_pkg::ONE_Q32 : prod_reg[54:22];
                mul_a  = MW'(t_next);
                mul_b  = MW'(t_next);
            end
            gmi_pkg::ST_MUL_T2:
            begin
                t2_next = prod_reg[64:32];
                mul_a   = MW'(t2_next);
                mul_b   = MW'(t_reg);
            end
            gmi_pkg::ST_MUL_T3:
            begin
                mul_a = MW'(prod_reg[64:32]);
                mul_b = gmi_pkg::RECIP6;
            end
            gmi_pkg::ST_MUL_P:
            begin
                mul_a = MW'(rom_word_reg[gmi_pkg::GAUSS_W-1:0]);
                mul_b = MW'(p_val);
            end
            gmi_pkg::ST_ACC:
            begin
                sum_next = sum_wide[gmi_pkg::SUM_W] ? '1 : sum_wide[gmi_pkg::SUM_W-1:0];
                pos_next = pos_reg + h_val;
                idx_next = idx_inc;
            end
            gmi_pkg::ST_SCALE_LO:
            begin
                mul_a = MW'(sum_reg[23:0]);
                mul_b = MW'(quo_reg);
            end
            gmi_pkg::ST_SCALE_HI:
            begin
                lo_next = prod_reg[55:24];
                mul_a   = MW'(sum_reg[gmi_pkg::SUM_W-1:24]);
                mul_b   = MW'(quo_reg);
            end
            gmi_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (!neg_reg)
                    begin
                        integral_next = (mag > 52'h0_0000_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                     : mag[31:0];
                    end
                    else
                    begin
                        integral_next = (mag > 52'h0_0000_8000_0000) ? 32'h8000_0000
                                                                     : (32'd0 - mag[31:0]);
                    end
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && !rsp_ready;
            end
        endcase

        // hold the scaled product while the result waits
        prod_next = (state_reg == gmi_pkg::ST_FINISH) ? prod_reg
                                                      : PW'(mul_a) * PW'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmi_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            div_cnt_reg   <= div_cnt_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        integral_reg <= integral_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        a_reg        <= a_next;
        n_reg        <= n_next;
        pos_reg      <= pos_next;
        ax_reg       <= ax_next;
        prod_reg     <= prod_next;
        zero_reg     <= zero_next;
        t_reg        <= t_next;
        t2_reg       <= t2_next;
        sum_reg      <= sum_next;
        lo_reg       <= lo_next;
        if (rom_rd)
        begin
            rom_word_reg <= rom_tab[rom_addr];
        end
    end

endmodule

// File: rtl/gmi_checker.sv
// Port-level checks for midpoint_gaussian_integrator, bound to the top level.
// Depends only on the top level's ports.
module gmi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] integral
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(integral))
        else $error("stalled result changed or dropped");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready ##1 !req_ready)
        else $error("request taken while a job is running");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid))
        else $error("ready dropped without a request");

    a_rsp_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $rose(req_ready))
        else $error("result appeared outside job completion");

endmodule

bind midpoint_gaussian_integrator gmi_checker u_gmi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .integral  (integral)
);
